>>> sv/rls_pkg.sv
// Package with shared constants, types and tables for the row log-softmax block.
package rls_pkg;

    localparam int unsigned StoreDepth = 64;
    localparam int unsigned ValueW     = 16;
    localparam int unsigned ExpW       = 31;
    localparam int unsigned SumW       = 37;
    localparam int unsigned ExpBits    = 13;
    localparam int unsigned LnW        = 24;
    localparam logic signed [15:0] Q8Min = 16'sh8000;
    localparam logic [17:0] Ln2Q16 = 18'd45426;

    typedef logic [ExpW-1:0] t_exp;
    typedef logic [SumW-1:0] t_sum;

    // Factor exp(-2^(k-8)) in Q0.30 for bit k of the distance.
    function automatic logic [29:0] exp_bit_q30(input logic [3:0] k);
        logic [29:0] r;
        begin
            case (k)
                4'd0:    r = 30'd1069555701;
                4'd1:    r = 30'd1065385899;
                4'd2:    r = 30'd1057095000;
                4'd3:    r = 30'd1040706261;
                4'd4:    r = 30'd1008687096;
                4'd5:    r = 30'd947573834;
                4'd6:    r = 30'd836230973;
                4'd7:    r = 30'd651257337;
                4'd8:    r = 30'd395007542;
                4'd9:    r = 30'd145315154;
                4'd10:   r = 30'd19666268;
                4'd11:   r = 30'd360200;
                4'd12:   r = 30'd121;
                default: r = 30'd0;
            endcase
            return r;
        end
    endfunction

    // ln(1 + i/16) in Q16.
    function automatic logic [15:0] ln_frac_q16(input logic [4:0] i);
        logic [15:0] r;
        begin
            case (i)
                5'd0:    r = 16'd0;
                5'd1:    r = 16'd3973;
                5'd2:    r = 16'd7719;
                5'd3:    r = 16'd11262;
                5'd4:    r = 16'd14624;
                5'd5:    r = 16'd17821;
                5'd6:    r = 16'd20870;
                5'd7:    r = 16'd23783;
                5'd8:    r = 16'd26573;
                5'd9:    r = 16'd29248;
                5'd10:   r = 16'd31818;
                5'd11:   r = 16'd34292;
                5'd12:   r = 16'd36675;
                5'd13:   r = 16'd38975;
                5'd14:   r = 16'd41196;
                5'd15:   r = 16'd43345;
                5'd16:   r = 16'd45426;
                default: r = 16'd0;
            endcase
            return r;
        end
    endfunction

endpackage

>>> sv/rls_exp_unit.sv
// Iterative exp(-t/256) unit in Q0.30, one table factor per cycle.
module rls_exp_unit
    import rls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_dist,
    output logic        o_done,
    output t_exp        o_value
);

    logic        r_busy;
    logic [3:0]  r_bit;
    logic [12:0] r_dist;
    logic        r_zero;
    t_exp        r_acc;
    logic        r_done;
    logic [60:0] w_prod;

    assign w_prod = r_acc * exp_bit_q30(r_bit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == 4'(ExpBits - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bit  <= 4'd0;
            r_dist <= i_dist[12:0];
            r_zero <= (i_dist >= 17'd8192);
            r_acc  <= ExpW'(31'h4000_0000);
        end else if (r_busy) begin
            r_bit <= r_bit + 4'd1;
            if (r_dist[r_bit]) begin
                r_acc <= w_prod[30+ExpW-1:30];
            end
        end
    end

    assign o_done  = r_done;
    assign o_value = r_zero ? '0 : r_acc;

endmodule

>>> sv/rls_ln_unit.sv
// Natural log of the Q0.30 exp sum, result rounded to Q8.8.
module rls_ln_unit
    import rls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_sum        i_sum,
    output logic        o_done,
    output logic [15:0] o_lq8
);

    localparam logic [2:0] LnIdle = 3'd0;
    localparam logic [2:0] LnNorm = 3'd1;
    localparam logic [2:0] LnMul  = 3'd2;
    localparam logic [2:0] LnAdd  = 3'd3;
    localparam logic [2:0] LnDone = 3'd4;

    logic [2:0]  r_state, n_state;
    t_sum        r_sum;
    logic [5:0]  r_k;
    logic        r_small;
    logic [3:0]  r_idx;
    logic [15:0] r_rem;
    logic [15:0] r_lo;
    logic [31:0] r_prod;
    logic [15:0] r_lq8;
    logic [5:0]  w_k;
    t_sum        w_norm;
    logic signed [LnW+1:0] w_ln;
    logic signed [LnW+1:0] w_round;

    always_comb begin
        w_k = 6'd0;
        for (int b = 0; b < SumW; b++) begin
            if (r_sum[b]) begin
                w_k = 6'(b);
            end
        end
    end

    // Top bit moved to position SumW-1.
    assign w_norm = r_sum << (6'(SumW - 1) - w_k);

    // The bit position is unsigned, so it is zero-extended before the offset.
    assign w_ln = ($signed({{(LnW-4){1'b0}}, r_k}) - 26'sd30) * $signed({8'd0, Ln2Q16})
                  + $signed({10'd0, r_lo}) + $signed({10'd0, r_prod[31:16]});
    assign w_round = (w_ln + 26'sd128) >>> 8;

    always_comb begin
        n_state = r_state;
        case (r_state)
            LnIdle:  if (i_start) n_state = LnNorm;
            LnNorm:  n_state = LnMul;
            LnMul:   n_state = LnAdd;
            LnAdd:   n_state = LnDone;
            LnDone:  n_state = LnIdle;
            default: n_state = LnIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LnIdle;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            LnIdle: if (i_start) r_sum <= i_sum;
            LnNorm: begin
                r_k     <= w_k;
                r_small <= (r_sum < t_sum'(37'h4000_0000));
                r_idx   <= w_norm[SumW-2:SumW-5];
                r_rem   <= w_norm[SumW-6:SumW-21];
            end
            LnMul: begin
                r_lo   <= ln_frac_q16({1'b0, r_idx});
                r_prod <= 32'((ln_frac_q16(5'({1'b0, r_idx}) + 5'd1)
                         - ln_frac_q16({1'b0, r_idx})) * r_rem);
            end
            LnAdd: r_lq8 <= r_small ? 16'd0 : w_round[15:0];
            default: ;
        endcase
    end

    assign o_done = (r_state == LnDone);
    assign o_lq8  = r_lq8;

endmodule

>>> sv/row_log_softmax.sv
// Top level of the row log-softmax block: row store, sequencer and output stage.
//
// Elements of a row are written into a MAX_COLS-entry (64 by default) row memory
// with one write and one read port, one request per cycle while busy is low, and a
// running maximum is kept. The request marked row_end raises busy; the block then
// reads the row back once for the exp sum, each element in turn (address, read,
// start pulse, 13 factor steps in the exp unit and its done cycle), takes the log
// (normalise, table multiply, add and round), and reads the row a second time to
// emit one result per cycle on o_result_valid. The exp unit sets the pace. The
// receiver cannot stall: each result shows for one cycle. Elements beyond
// MAX_COLS are dropped and flag every result of the row.
module row_log_softmax
    import rls_pkg::*;
#(
    parameter int unsigned MAX_COLS = StoreDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [ValueW-1:0] i_element_value,
    input  logic        i_row_end,
    output logic        o_result_valid,
    output logic signed [ValueW-1:0] o_out_value,
    output logic        o_run_end,
    output logic        o_row_overflow
);

    localparam int unsigned AddrW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int unsigned CntW  = $clog2(MAX_COLS + 1);

    localparam logic [2:0] StLoad = 3'd0;
    localparam logic [2:0] StRead = 3'd1;
    localparam logic [2:0] StExp  = 3'd2;
    localparam logic [2:0] StLn   = 3'd3;
    localparam logic [2:0] StEmit = 3'd4;
    localparam logic [2:0] StPrep = 3'd5;

    logic signed [ValueW-1:0] r_mem [MAX_COLS];
    logic signed [ValueW-1:0] r_rdata;

    logic [2:0]      r_state;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_idx;
    logic signed [ValueW-1:0] r_max;
    logic            r_drop;
    t_sum            r_sum;
    logic [15:0]     r_lq8;
    logic            r_exp_start;
    logic            r_ln_start;
    logic            r_emit_pend;
    logic [CntW-1:0] r_emit_idx;
    logic            r_valid;
    logic signed [ValueW-1:0] r_out;
    logic            r_last;
    logic            r_ovf;

    logic            w_accept;
    logic            w_store;
    logic            w_exp_done;
    t_exp            w_exp_val;
    logic            w_ln_done;
    logic [15:0]     w_ln_val;
    logic [AddrW-1:0] w_raddr;
    logic signed [17:0] w_diff;
    logic signed [18:0] w_y;

    assign busy     = (r_state != StLoad);
    assign w_accept = start && !busy;
    assign w_store  = w_accept && (r_count < CntW'(MAX_COLS));
    assign w_raddr  = r_idx[AddrW-1:0];

    // Row memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_count[AddrW-1:0]] <= i_element_value;
        end
        r_rdata <= r_mem[w_raddr];
    end

    assign w_diff = 18'(r_max) - 18'(r_rdata);

    rls_exp_unit u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_exp_start),
        .i_dist  (w_diff[16:0]),
        .o_done  (w_exp_done),
        .o_value (w_exp_val)
    );

    rls_ln_unit u_ln (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_ln_start),
        .i_sum   (r_sum),
        .o_done  (w_ln_done),
        .o_lq8   (w_ln_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StLoad;
            r_count     <= '0;
            r_max       <= Q8Min;
            r_drop      <= 1'b0;
            r_exp_start <= 1'b0;
            r_ln_start  <= 1'b0;
            r_emit_pend <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_exp_start <= 1'b0;
            r_ln_start  <= 1'b0;
            r_valid     <= 1'b0;
            case (r_state)
                StLoad: begin
                    if (w_accept) begin
                        if (w_store) begin
                            r_count <= r_count + CntW'(1);
                            if (i_element_value > r_max) r_max <= i_element_value;
                        end else begin
                            r_drop <= 1'b1;
                        end
                        if (i_row_end) begin
                            r_state <= StPrep;
                            r_idx   <= '0;
                            r_sum   <= '0;
                        end
                    end
                end
                StPrep: begin
                    // Present address r_idx; data arrives next cycle.
                    r_state <= StRead;
                end
                StRead: begin
                    r_exp_start <= 1'b1;
                    r_state     <= StExp;
                end
                StExp: begin
                    if (w_exp_done) begin
                        r_sum <= r_sum + t_sum'(w_exp_val);
                        if (r_idx + CntW'(1) == r_count) begin
                            r_state    <= StLn;
                            r_ln_start <= 1'b1;
                            r_idx      <= '0;
                        end else begin
                            r_idx   <= r_idx + CntW'(1);
                            r_state <= StPrep;
                        end
                    end
                end
                StLn: begin
                    if (w_ln_done) begin
                        r_lq8       <= w_ln_val;
                        r_state     <= StEmit;
                        r_idx       <= r_idx + CntW'(1);
                        r_emit_idx  <= '0;
                        r_emit_pend <= 1'b1;
                    end
                end
                StEmit: begin
                    // r_rdata holds entry r_emit_idx this cycle.
                    r_valid <= 1'b1;
                    r_out   <= (w_y < -19'sd32768) ? Q8Min : w_y[15:0];
                    r_last  <= (r_emit_idx + CntW'(1) == r_count);
                    r_ovf   <= r_drop;
                    r_emit_idx <= r_emit_idx + CntW'(1);
                    r_idx      <= r_idx + CntW'(1);
                    if (r_emit_idx + CntW'(1) == r_count) begin
                        r_state     <= StLoad;
                        r_count     <= '0;
                        r_max       <= Q8Min;
                        r_drop      <= 1'b0;
                        r_emit_pend <= 1'b0;
                    end
                end
                default: r_state <= StLoad;
            endcase
        end
    end

    assign w_y = 19'(r_rdata) - 19'(r_max) - 19'($signed(r_lq8));

    assign o_result_valid = r_valid;
    assign o_out_value    = r_out;
    assign o_run_end      = r_last;
    assign o_row_overflow = r_ovf;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MAX_COLS))
        else $error("element count beyond store depth");
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit_pend |-> busy)
        else $error("emission while idle");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_run_end) |-> !busy)
        else $error("row end without return to load");
    a_no_start_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_exp_start && r_ln_start))
        else $error("exp and log started together");
`endif

endmodule

>>> bench/row_log_softmax_checker.sv
// Checker for the row log-softmax block: predicts each row's results and compares them.
module row_log_softmax_checker
    import rls_pkg::*;
#(
    parameter int unsigned MAX_COLS = StoreDepth
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic signed [ValueW-1:0] i_element_value,
    input  logic                     i_row_end,
    input  logic                     o_result_valid,
    input  logic signed [ValueW-1:0] o_out_value,
    input  logic                     o_run_end,
    input  logic                     o_row_overflow,
    output int                       fail_count,
    output int                       pending_count,
    output int                       result_count
);

    typedef struct packed {
        logic signed [15:0] value;
        logic               last;
        logic               dropped;
    } t_softmax_result;

    localparam logic [63:0] ExpFactor [13] = '{
        64'd1069555701, 64'd1065385899, 64'd1057095000, 64'd1040706261,
        64'd1008687096, 64'd947573834, 64'd836230973, 64'd651257337,
        64'd395007542, 64'd145315154, 64'd19666268, 64'd360200, 64'd121
    };
    localparam int LnTable [17] = '{
        0, 3973, 7719, 11262, 14624, 17821, 20870, 23783, 26573,
        29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426
    };

    t_softmax_result expected_results[$];
    int  row_elems[$];
    int  row_peak;
    bit  row_lost;

    function automatic logic [63:0] decay_q30(int t);
        logic [63:0] p;
        p = 64'd1 << 30;
        if (t >= 8192) return 64'd0;
        for (int k = 0; k < 13; k++)
            if (t[k]) p = (p * ExpFactor[k]) >> 30;
        return p;
    endfunction

    function automatic longint log_q16(logic [63:0] s);
        int     k;
        int     idx;
        longint rem;
        longint lo;
        longint hi;
        k = 0;
        if (s < (64'd1 << 30)) return 0;
        for (int b = 0; b < 64; b++)
            if (s[b]) k = b;
        idx = int'((s >> (k - 4)) & 64'hF);
        rem = longint'((s >> (k - 20)) & 64'hFFFF);
        lo  = LnTable[idx];
        hi  = LnTable[idx + 1];
        return longint'(k - 30) * 45426 + lo + (((hi - lo) * rem) >>> 16);
    endfunction

    // Work out the whole row once its last request is in.
    task automatic predict_row();
        logic [63:0]     total;
        longint          lnv;
        int              offset;
        int              y;
        t_softmax_result r;
        total = 0;
        foreach (row_elems[i]) total += decay_q30(row_peak - row_elems[i]);
        lnv    = log_q16(total);
        offset = int'((lnv + 128) >>> 8);
        foreach (row_elems[i]) begin
            y = row_elems[i] - row_peak - offset;
            if (y < -32768) y = -32768;
            r.value   = y[15:0];
            r.last    = (i == row_elems.size() - 1);
            r.dropped = row_lost;
            expected_results.push_back(r);
        end
        row_elems.delete();
        row_peak = -32768;
        row_lost = 0;
    endtask

    always @(posedge i_clk) begin
        t_softmax_result e;
        if (!i_rst_n) begin
            row_elems.delete();
            row_peak = -32768;
            row_lost = 0;
        end else begin
            if (o_result_valid) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result value=%0d end=%0b ovf=%0b", $time,
                             o_out_value, o_run_end, o_row_overflow);
                end else begin
                    e = expected_results.pop_front();
                    if (o_out_value !== e.value || o_run_end !== e.last
                        || o_row_overflow !== e.dropped) begin
                        fail_count++;
                        $display("%0t: mismatch expected value=%0d end=%0b ovf=%0b, got value=%0d end=%0b ovf=%0b",
                                 $time, e.value, e.last, e.dropped,
                                 o_out_value, o_run_end, o_row_overflow);
                    end
                end
            end
            if (start && !busy) begin
                if (row_elems.size() < MAX_COLS) begin
                    row_elems.push_back(int'(i_element_value));
                    if (int'(i_element_value) > row_peak) row_peak = int'(i_element_value);
                end else begin
                    row_lost = 1;
                end
                if (i_row_end) predict_row();
            end
        end
        pending_count = expected_results.size();
    end

    initial begin
        fail_count    = 0;
        pending_count = 0;
        result_count  = 0;
    end

endmodule

>>> bench/row_log_softmax_tb.sv
// Testbench top for the row log-softmax block: stimulus, phases and verdict.
module row_log_softmax_tb;
    import rls_pkg::*;

    // Watchdog limit in cycles without any accepted request or result. The slowest
    // row, with 64 elements, stays well under this; sender gaps are short.
    localparam int WatchLimit = 5000;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic signed [ValueW-1:0] i_element_value;
    logic                     i_row_end;
    logic                     o_result_valid;
    logic signed [ValueW-1:0] o_out_value;
    logic                     o_run_end;
    logic                     o_row_overflow;
    int                       fail_count;
    int                       pending_count;
    int                       result_count;
    int                       request_count;
    int                       idle_pct;
    int                       quiet_cycles;

    row_log_softmax dut (.*);
    row_log_softmax_checker checker_i (.*);

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    // The watchdog restarts whenever a request or a result goes through.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit) begin
            $display("%0t: watchdog expired, %0d results still pending", $time, pending_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Presents one request and holds it until the block takes it. Before the
    // request, the sender may sit idle at the current idle percentage; start
    // falls only while the sender idles or drains.
    task automatic send_request(input logic signed [15:0] v, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge i_clk);
        end
        start           <= 1;
        i_element_value <= v;
        i_row_end       <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        request_count++;
    endtask

    // A random element: mostly near a common level so the exp sum sees many
    // close values, sometimes anywhere in the full range.
    function automatic logic signed [15:0] pick_value(int level);
        if ($urandom_range(3) == 0) return 16'($urandom);
        return 16'(level + int'($urandom_range(2047)) - 1024);
    endfunction

    task automatic send_row(int len);
        int level;
        level = int'($urandom_range(65535)) - 32768;
        for (int i = 0; i < len; i++) send_request(pick_value(level), i == len - 1);
    endtask

    // The first edge lets the checker register the last request before the wait.
    task automatic drain();
        start <= 0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int len;
        quiet_cycles    = 0;
        request_count   = 0;
        idle_pct        = 0;
        i_rst_n         <= 0;
        start           <= 0;
        i_element_value <= 0;
        i_row_end       <= 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed part: single-element rows at the extremes, a row where one
        // element sits far below the maximum (saturation), equal elements,
        // and a row that runs past the store and gets flagged.
        send_request(16'sh7fff, 1);
        send_request(-16'sd32768, 1);
        send_request(16'sh0000, 1);
        send_request(16'sh7fff, 0);
        send_request(-16'sd32768, 1);
        send_request(16'sh5555, 0);
        send_request(-16'sh2aab, 0);
        send_request(16'sh0100, 0);
        send_request(16'sh0100, 1);
        for (int i = 0; i < 4; i++) send_request(16'sh0000, i == 3);
        drain();
        // Too long a row: 66 elements, the last two are dropped and the last one ends the row.
        for (int i = 0; i < 66; i++) send_request(16'(i * 300 - 9000), i == 65);
        // The sender waits here for the whole row before moving on.
        drain();

        // Random short rows over the idle phases.
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1 || phase == 3) ? 82 : (phase == 2 ? 38 : 0);
            for (int r = 0; r < 7; r++) begin
                len = int'($urandom_range(6, 1));
                send_row(len);
            end
        end
        drain();

        $display("Covered %0d requests and %0d results: extremes, saturation, overflow rows,",
                 request_count, result_count);
        $display("and random rows under sender idle rates of 0, 38 and 82 percent.");
        if (fail_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
sv/rls_pkg.sv
sv/rls_exp_unit.sv
sv/rls_ln_unit.sv
sv/row_log_softmax.sv
bench/row_log_softmax_checker.sv
bench/row_log_softmax_tb.sv
